/* rtl/core/owbm_pkg.sv */
// Shared types, codes and constants of the one-wire bus master.
package owbm_pkg;

    localparam int COUNT_BITS   = 10;
    localparam int SETTLE_TICKS = 5;
    localparam int CFG_W        = 10;
    localparam int CFG_IDX_W    = 3;

    localparam logic [31:0] CMAX32 = (32'd1 << COUNT_BITS) - 32'd1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = CMAX32[COUNT_BITS-1:0];

    // Opcodes carried in tuser.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_RESET = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_RBYTE = 3'd3;
    localparam logic [2:0] OP_RBIT  = 3'd4;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_SAMP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_FIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPU_EN     = 3'd7;

    localparam logic [CFG_W-1:0] DEF_RESET_LOW = 10'd480;
    localparam logic [CFG_W-1:0] DEF_PRES_SAMP = 10'd70;
    localparam logic [CFG_W-1:0] DEF_RESET_FIN = 10'd410;
    localparam logic [CFG_W-1:0] DEF_SHORT_LOW = 10'd6;
    localparam logic [CFG_W-1:0] DEF_LONG_LOW  = 10'd60;
    localparam logic [CFG_W-1:0] DEF_READ_SAMP = 10'd15;
    localparam logic [CFG_W-1:0] DEF_SLOT      = 10'd70;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PRES  = 2'd1;
    localparam logic [1:0] ST_STUCK    = 2'd2;
    localparam logic [1:0] ST_BUSY     = 2'd3;

    localparam logic [7:0] CRC_POLY = 8'h8c;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_CMD  = 2'd1,
        KIND_NOP  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] opcode;
        logic [7:0] data_byte;
        logic       pull_after;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic [7:0] crc_value;
        logic [1:0] status_code;
        logic [7:0] read_value;
        logic       done_res;
        logic       busy_res;
        logic       drive_high;
        logic       drive_low;
    } t_result;

    // Timing registers: zero counts as one, values above the counter clamp to its top.
    function automatic logic [COUNT_BITS-1:0] eff_ticks(input logic [31:0] v);
        logic [31:0] w;
        w = v;
        if (w == 32'd0) w = 32'd1;
        if (w > CMAX32) w = CMAX32;
        return w[COUNT_BITS-1:0];
    endfunction

    localparam logic [COUNT_BITS-1:0] SETTLE_EFF = eff_ticks(32'(SETTLE_TICKS));

endpackage

/* rtl/core/owbm_front.sv */
// Front end: accepts stream items, classifies them and queues them for the sequencer.
module owbm_front import owbm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_pull_after,
    input  logic        i_line_level,
    output logic        o_valid,
    input  logic        i_pop,
    output t_item       o_item
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_item      w_item;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_item.opcode     = i_opcode;
        w_item.data_byte  = i_data_byte;
        w_item.pull_after = i_pull_after;
        w_item.line_level = i_line_level;
        unique case (i_opcode) inside
            OP_TICK:                             w_item.kind = KIND_TICK;
            OP_RESET, OP_WRITE, OP_RBYTE, OP_RBIT: w_item.kind = KIND_CMD;
            default:                             w_item.kind = KIND_NOP;
        endcase
    end

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= w_item;
    end

endmodule

/* rtl/core/owbm_back.sv */
// Back end: bus sequencer, configuration registers, CRC and result register.
module owbm_back import owbm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_pop,
    input  t_item                i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_result              o_result
);

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_SETTLE = 6'b000010,
        PH_RLOW   = 6'b000100,
        PH_RWAIT  = 6'b001000,
        PH_RFIN   = 6'b010000,
        PH_SLOT   = 6'b100000
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [2:0]            r_cmd, n_cmd;
    logic [COUNT_BITS-1:0] r_tick, n_tick;
    logic [3:0]            r_bit, n_bit;
    logic [7:0]            r_shift, n_shift;
    logic                  r_presence, n_presence;
    logic [7:0]            r_crc, n_crc;
    logic                  r_pull_pend, n_pull_pend;
    logic                  r_high_drive, n_high_drive;
    logic [1:0]            r_last_status, n_last_status;
    logic [7:0]            r_read_hold, n_read_hold;

    logic [COUNT_BITS-1:0] r_reset_low, r_pres_samp, r_reset_fin;
    logic [COUNT_BITS-1:0] r_short_low, r_long_low, r_read_samp, r_slot;
    logic                  r_spu_en;

    logic                  r_out_valid;
    t_result               r_out;
    t_result               w_res;
    logic                  w_take;

    logic [COUNT_BITS-1:0] w_t;
    logic [COUNT_BITS-1:0] w_samp;
    logic [COUNT_BITS-1:0] w_low;
    logic [3:0]            w_nbits;
    logic                  w_finish;
    logic [1:0]            w_fin_status;
    logic                  w_reject;

    function automatic logic [7:0] crc8(input logic [7:0] crc_in, input logic [7:0] data_in);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc_in;
        d = data_in;
        for (int i = 0; i < 8; i++) begin
            mix = c[0] ^ d[0];
            c   = c >> 1;
            if (mix) c = c ^ CRC_POLY;
            d   = d >> 1;
        end
        return c;
    endfunction

    assign o_pop  = !r_out_valid || i_ready;
    assign w_take = i_valid && o_pop;

    // The read sample point never lies past the end of the slot.
    assign w_samp  = (r_read_samp > r_slot) ? r_slot : r_read_samp;
    assign w_nbits = (r_cmd == OP_RBIT) ? 4'd1 : 4'd8;
    assign w_t     = (r_tick == CNT_MAX) ? r_tick : r_tick + 1'b1;

    always_comb begin
        n_phase       = r_phase;
        n_cmd         = r_cmd;
        n_tick        = r_tick;
        n_bit         = r_bit;
        n_shift       = r_shift;
        n_presence    = r_presence;
        n_crc         = r_crc;
        n_pull_pend   = r_pull_pend;
        n_high_drive  = r_high_drive;
        n_last_status = r_last_status;
        n_read_hold   = r_read_hold;
        w_finish      = 1'b0;
        w_fin_status  = ST_OK;
        w_reject      = 1'b0;

        if (w_take) begin
            unique case (i_item.kind)
                KIND_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        n_tick = w_t;
                        unique case (r_phase)
                            PH_SETTLE: begin
                                if (w_t >= SETTLE_EFF) begin
                                    if (!i_item.line_level) begin
                                        w_finish     = 1'b1;
                                        w_fin_status = ST_STUCK;
                                    end else begin
                                        n_phase = PH_RLOW;
                                        n_tick  = '0;
                                    end
                                end
                            end
                            PH_RLOW: begin
                                if (w_t >= r_reset_low) begin
                                    n_phase = PH_RWAIT;
                                    n_tick  = '0;
                                end
                            end
                            PH_RWAIT: begin
                                if (w_t >= r_pres_samp) begin
                                    n_presence = !i_item.line_level;
                                    n_phase    = PH_RFIN;
                                    n_tick     = '0;
                                end
                            end
                            PH_RFIN: begin
                                if (w_t >= r_reset_fin) begin
                                    w_finish = 1'b1;
                                    if (!r_presence)             w_fin_status = ST_NO_PRES;
                                    else if (!i_item.line_level) w_fin_status = ST_STUCK;
                                    else                         w_fin_status = ST_OK;
                                end
                            end
                            PH_SLOT: begin
                                if (r_cmd != OP_WRITE && w_t == w_samp) begin
                                    if (r_cmd == OP_RBYTE)
                                        n_shift = {i_item.line_level, r_shift[7:1]};
                                    else
                                        n_shift = {7'd0, i_item.line_level};
                                end
                                if (w_t >= r_slot) begin
                                    n_bit = r_bit + 4'd1;
                                    if (n_bit >= w_nbits) begin
                                        w_finish     = 1'b1;
                                        w_fin_status = ST_OK;
                                    end else begin
                                        n_tick = '0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                KIND_CMD: begin
                    if (r_phase != PH_IDLE) begin
                        w_reject = 1'b1;
                    end else begin
                        n_cmd         = i_item.opcode;
                        n_tick        = '0;
                        n_bit         = 4'd0;
                        n_shift       = 8'd0;
                        n_high_drive  = 1'b0;
                        n_pull_pend   = 1'b0;
                        n_last_status = ST_OK;
                        if (i_item.opcode == OP_RESET) begin
                            n_crc      = 8'd0;
                            n_presence = 1'b0;
                            n_phase    = PH_SETTLE;
                        end else begin
                            if (i_item.opcode == OP_WRITE) begin
                                n_shift     = i_item.data_byte;
                                n_pull_pend = i_item.pull_after & r_spu_en;
                            end
                            n_phase = PH_SLOT;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (w_finish) begin
            if (r_cmd == OP_WRITE) begin
                n_high_drive = r_pull_pend;
                n_pull_pend  = 1'b0;
            end else if (r_cmd == OP_RBYTE) begin
                n_read_hold = n_shift;
                n_crc       = crc8(r_crc, n_shift);
            end else if (r_cmd == OP_RBIT) begin
                n_read_hold = {7'd0, n_shift[0]};
            end
            n_last_status = w_fin_status;
            n_phase       = PH_IDLE;
            n_tick        = '0;
        end
    end

    // Low time of the current slot: a zero bit of a write takes the long pulse.
    assign w_low = (n_cmd == OP_WRITE && !n_shift[n_bit[2:0]]) ? r_long_low : r_short_low;

    always_comb begin
        w_res.drive_low   = (n_phase == PH_RLOW) || (n_phase == PH_SLOT && n_tick < w_low);
        w_res.drive_high  = (n_phase == PH_IDLE) && n_high_drive && r_spu_en;
        w_res.busy_res    = (n_phase != PH_IDLE);
        w_res.done_res    = w_finish;
        w_res.read_value  = n_read_hold;
        w_res.status_code = w_reject ? ST_BUSY : n_last_status;
        w_res.crc_value   = n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_cmd         <= 3'd0;
            r_tick        <= '0;
            r_bit         <= 4'd0;
            r_shift       <= 8'd0;
            r_presence    <= 1'b0;
            r_crc         <= 8'd0;
            r_pull_pend   <= 1'b0;
            r_high_drive  <= 1'b0;
            r_last_status <= ST_OK;
            r_read_hold   <= 8'd0;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_cmd         <= n_cmd;
            r_tick        <= n_tick;
            r_bit         <= n_bit;
            r_shift       <= n_shift;
            r_presence    <= n_presence;
            r_crc         <= n_crc;
            r_pull_pend   <= n_pull_pend;
            r_high_drive  <= n_high_drive;
            r_last_status <= n_last_status;
            r_read_hold   <= n_read_hold;
            if (w_take)       r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_out <= w_res;
    end

    // Timing registers are kept in their effective form.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low <= eff_ticks(32'(DEF_RESET_LOW));
            r_pres_samp <= eff_ticks(32'(DEF_PRES_SAMP));
            r_reset_fin <= eff_ticks(32'(DEF_RESET_FIN));
            r_short_low <= eff_ticks(32'(DEF_SHORT_LOW));
            r_long_low  <= eff_ticks(32'(DEF_LONG_LOW));
            r_read_samp <= eff_ticks(32'(DEF_READ_SAMP));
            r_slot      <= eff_ticks(32'(DEF_SLOT));
            r_spu_en    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RESET_LOW: r_reset_low <= eff_ticks(32'(i_cfg_data));
                CFG_PRES_SAMP: r_pres_samp <= eff_ticks(32'(i_cfg_data));
                CFG_RESET_FIN: r_reset_fin <= eff_ticks(32'(i_cfg_data));
                CFG_SHORT_LOW: r_short_low <= eff_ticks(32'(i_cfg_data));
                CFG_LONG_LOW:  r_long_low  <= eff_ticks(32'(i_cfg_data));
                CFG_READ_SAMP: r_read_samp <= eff_ticks(32'(i_cfg_data));
                CFG_SLOT:      r_slot      <= eff_ticks(32'(i_cfg_data));
                CFG_SPU_EN:    r_spu_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

/* rtl/core/one_wire_bus_master.sv */
// One-wire bus master: stream ports, front queue and bus sequencer.
//
// Every item on the input stream is either a one-microsecond tick (tuser opcode zero,
// tdata[9] carrying the sampled line level) or a command: reset with presence detect,
// write byte (tdata[7:0], tdata[8] asks for a strong pull-up afterwards), read byte
// or read bit. Each item yields exactly one result transaction on the output stream
// showing the line drive, busy and done flags, last read value, status and CRC-8.
// A command arriving while another one runs is answered with status 3 and dropped.
// The front end classifies items into a two-entry queue; the sequencer takes one
// item per cycle from it into the output register unless the receiver stalls, so
// throughput is one item per clock; each item is registered in the queue and then
// in the result register before output valid rises. When the receiver stalls, the
// result register holds, the queue fills and s_axis_tready falls after two more items.
// Configuration writes are always taken (o_cfg_ready high) and must only be issued
// while no command runs and no result is outstanding.
// Synchronous active-low reset empties the queue and result register, returns the
// sequencer to idle, clears CRC, status and read value, and loads default timing.
module one_wire_bus_master import owbm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,  // data_byte[7:0], pull_after[8], line_level[9]
    input  logic [2:0]           s_axis_tuser,  // opcode[2:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // drive_low[0], drive_high[1], busy_res[2], done_res[3], read_value[11:4],
    // status_code[13:12], crc_value[21:14]
    output logic [23:0]          m_axis_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic    w_q_valid;
    logic    w_pop;
    t_item   w_item;
    t_result w_res;

    owbm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_opcode     (s_axis_tuser),
        .i_data_byte  (s_axis_tdata[7:0]),
        .i_pull_after (s_axis_tdata[8]),
        .i_line_level (s_axis_tdata[9]),
        .o_valid      (w_q_valid),
        .i_pop        (w_pop),
        .o_item       (w_item)
    );

    owbm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (w_q_valid),
        .o_pop       (w_pop),
        .i_item      (w_item),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (w_res)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {2'b00, w_res.crc_value, w_res.status_code, w_res.read_value,
                           w_res.done_res, w_res.busy_res, w_res.drive_high,
                           w_res.drive_low};

endmodule

/* rtl/core/owbm_checker.sv */
// Port-level assertions for the one-wire bus master, bound to the top level.
module owbm_checker import owbm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The line is never pulled low and driven high together.
    a_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("drive low and drive high together");

    // A completing command leaves the master idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
        else $error("done while still busy");

    // A rejected command happens only while busy and never completes anything.
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13:12] == ST_BUSY |-> m_axis_tdata[2] && !m_axis_tdata[3])
        else $error("busy rejection without a running command");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (.*);

/* test/tb_one_wire_bus_master.sv */
// Self-checking testbench of the one-wire bus master: directed table, slow commands, then random traffic.
module tb_one_wire_bus_master;
    import owbm_pkg::*;

    localparam int RAND_ITEMS = 850;
    localparam int QUIET_ITEMS = 150;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    // Opcodes with no function; the block must only echo its state.
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_RLOW,
        PH_RWAIT,
        PH_RFIN,
        PH_SLOT
    } t_phase;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       pull;
        logic       line;
        logic [3:0] reps;
        logic       known;
        t_result    want;
    } t_row;

    localparam t_result R_IDLE = '0;
    localparam t_result R_START = '{crc_value: 8'h00, status_code: ST_OK, read_value: 8'h00,
                                    done_res: 1'b0, busy_res: 1'b1, drive_high: 1'b0,
                                    drive_low: 1'b0};
    localparam t_result R_REJECT = '{crc_value: 8'h00, status_code: ST_BUSY, read_value: 8'h00,
                                     done_res: 1'b0, busy_res: 1'b1, drive_high: 1'b0,
                                     drive_low: 1'b0};

    localparam int N_DIR = 12;
    // Runs with timing registers at their smallest, long low time apart, so one slot is a single tick.
    localparam t_row DIR_ROWS [N_DIR] = '{
        '{OP_TICK,   8'h00, 1'b0, 1'b0, 4'd1, 1'b1, R_IDLE},
        '{OP_SPARE5, 8'hff, 1'b1, 1'b1, 4'd1, 1'b1, R_IDLE},
        '{OP_SPARE7, 8'h00, 1'b0, 1'b0, 4'd1, 1'b1, R_IDLE},
        '{OP_RESET,  8'h5a, 1'b1, 1'b1, 4'd1, 1'b1, R_START},
        '{OP_RBIT,   8'h00, 1'b0, 1'b1, 4'd1, 1'b1, R_REJECT},
        '{OP_TICK,   8'h00, 1'b0, 1'b0, 4'd5, 1'b0, R_IDLE},
        '{OP_WRITE,  8'h00, 1'b1, 1'b1, 4'd1, 1'b0, R_IDLE},
        '{OP_TICK,   8'h00, 1'b0, 1'b1, 4'd8, 1'b0, R_IDLE},
        '{OP_TICK,   8'hff, 1'b1, 1'b0, 4'd1, 1'b0, R_IDLE},
        '{OP_RBIT,   8'h00, 1'b0, 1'b0, 4'd1, 1'b0, R_IDLE},
        '{OP_TICK,   8'h00, 1'b0, 1'b1, 4'd1, 1'b0, R_IDLE},
        '{OP_SPARE6, 8'h33, 1'b0, 1'b1, 4'd1, 1'b0, R_IDLE}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [15:0]          s_tdata = '0;
    logic [2:0]           s_tuser = OP_TICK;
    logic                 m_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_RESET_LOW;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [23:0]          m_axis_tdata;
    logic                 o_cfg_ready;

    // Bus model state.
    t_phase     ph = PH_IDLE;
    logic [2:0] cmd;
    logic [9:0] cnt;
    logic [3:0] bidx;
    logic [7:0] shreg;
    logic [7:0] crc;
    logic [7:0] rd_hold;
    logic       pres;
    logic       pend;
    logic       hdrive;
    logic [1:0] last_st;
    logic [9:0] cfg_r [8];
    logic [9:0] cfg_next [8];

    t_result owed_results [$];
    int      n_items = 0;
    int      n_err = 0;
    int      n_rejects = 0;
    int      n_done = 0;
    int      n_loads = 0;
    int      n_reset_end [4] = '{0, 0, 0, 0};
    int      rand_base = 0;
    bit      rand_on = 1'b0;
    logic    quiet = 1'b0;
    logic    rx_hold = 1'b0;

    one_wire_bus_master u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // The registers are exactly as wide as the counter, so only zero needs fixing.
    function automatic logic [9:0] at_least_one(input logic [9:0] v);
        return (v == '0) ? 10'd1 : v;
    endfunction

    function automatic logic [7:0] crc8_fold(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] x;
        logic [7:0] v;
        x = c;
        v = d;
        for (int i = 0; i < 8; i++) begin
            if (x[0] ^ v[0]) x = (x >> 1) ^ CRC_POLY;
            else x = x >> 1;
            v = v >> 1;
        end
        return x;
    endfunction

    function automatic logic [9:0] slot_low();
        if (cmd == OP_WRITE && !shreg[bidx[2:0]]) return at_least_one(cfg_r[CFG_LONG_LOW]);
        return at_least_one(cfg_r[CFG_SHORT_LOW]);
    endfunction

    function automatic void reset_model();
        ph = PH_IDLE;
        cmd = OP_TICK;
        cnt = '0;
        bidx = '0;
        shreg = '0;
        crc = '0;
        rd_hold = '0;
        pres = 1'b0;
        pend = 1'b0;
        hdrive = 1'b0;
        last_st = ST_OK;
        cfg_r[CFG_RESET_LOW] = DEF_RESET_LOW;
        cfg_r[CFG_PRES_SAMP] = DEF_PRES_SAMP;
        cfg_r[CFG_RESET_FIN] = DEF_RESET_FIN;
        cfg_r[CFG_SHORT_LOW] = DEF_SHORT_LOW;
        cfg_r[CFG_LONG_LOW]  = DEF_LONG_LOW;
        cfg_r[CFG_READ_SAMP] = DEF_READ_SAMP;
        cfg_r[CFG_SLOT]      = DEF_SLOT;
        cfg_r[CFG_SPU_EN]    = '0;
    endfunction

    function automatic void close_cmd(input logic [1:0] st);
        if (cmd == OP_WRITE) begin
            hdrive = pend;
            pend = 1'b0;
        end else if (cmd == OP_RBYTE) begin
            rd_hold = shreg;
            crc = crc8_fold(crc, shreg);
        end else if (cmd == OP_RBIT) begin
            rd_hold = {7'b0, shreg[0]};
        end
        last_st = st;
        ph = PH_IDLE;
        cnt = '0;
    endfunction

    // Advances the running command by one tick; returns 1 when it completes.
    function automatic logic tick_step(input logic l);
        logic [9:0] t;
        logic [9:0] slot;
        logic [9:0] samp;
        t = (cnt < CNT_MAX) ? cnt + 10'd1 : cnt;
        cnt = t;
        case (ph)
            PH_SETTLE: begin
                if (t >= at_least_one(10'(SETTLE_TICKS))) begin
                    if (!l) begin
                        close_cmd(ST_STUCK);
                        return 1'b1;
                    end
                    ph = PH_RLOW;
                    cnt = '0;
                end
            end
            PH_RLOW: begin
                if (t >= at_least_one(cfg_r[CFG_RESET_LOW])) begin
                    ph = PH_RWAIT;
                    cnt = '0;
                end
            end
            PH_RWAIT: begin
                if (t >= at_least_one(cfg_r[CFG_PRES_SAMP])) begin
                    pres = !l;
                    ph = PH_RFIN;
                    cnt = '0;
                end
            end
            PH_RFIN: begin
                if (t >= at_least_one(cfg_r[CFG_RESET_FIN])) begin
                    close_cmd(!pres ? ST_NO_PRES : (!l ? ST_STUCK : ST_OK));
                    return 1'b1;
                end
            end
            PH_SLOT: begin
                slot = at_least_one(cfg_r[CFG_SLOT]);
                samp = at_least_one(cfg_r[CFG_READ_SAMP]);
                if (samp > slot) samp = slot;
                if (cmd != OP_WRITE && t == samp)
                    shreg = (cmd == OP_RBYTE) ? {l, shreg[7:1]} : {7'b0, l};
                if (t >= slot) begin
                    bidx = bidx + 4'd1;
                    if (bidx >= ((cmd == OP_RBIT) ? 4'd1 : 4'd8)) begin
                        close_cmd(ST_OK);
                        return 1'b1;
                    end
                    cnt = '0;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Applies one input item to the bus model and returns the result it produces.
    function automatic t_result bus_step(input logic [2:0] op, input logic [7:0] d,
                                         input logic p, input logic l);
        t_result    r;
        logic       done;
        logic [1:0] st;
        done = 1'b0;
        if (op == OP_TICK) begin
            if (ph != PH_IDLE) done = tick_step(l);
            st = last_st;
        end else if (op <= OP_RBIT) begin
            if (ph != PH_IDLE) begin
                st = ST_BUSY;
            end else begin
                cmd = op;
                cnt = '0;
                bidx = '0;
                shreg = '0;
                hdrive = 1'b0;
                pend = 1'b0;
                last_st = ST_OK;
                if (op == OP_RESET) begin
                    crc = '0;
                    pres = 1'b0;
                    ph = PH_SETTLE;
                end else begin
                    if (op == OP_WRITE) begin
                        shreg = d;
                        pend = p & cfg_r[CFG_SPU_EN][0];
                    end
                    ph = PH_SLOT;
                end
                st = ST_OK;
            end
        end else begin
            st = last_st;
        end
        r.drive_low   = (ph == PH_RLOW) || (ph == PH_SLOT && cnt < slot_low());
        r.drive_high  = (ph == PH_IDLE) ? (hdrive & cfg_r[CFG_SPU_EN][0]) : 1'b0;
        r.busy_res    = (ph != PH_IDLE);
        r.done_res    = done;
        r.read_value  = rd_hold;
        r.status_code = st;
        r.crc_value   = crc;
        return r;
    endfunction

    // Line level a well-behaved slave would mostly leave in the current phase; random if not tidy.
    function automatic logic device_line(input bit tidy);
        if (!tidy) return 1'($urandom_range(0, 1));
        case (ph)
            PH_SETTLE: return $urandom_range(0, 19) != 0;
            PH_RLOW:   return 1'b0;
            PH_RWAIT:  return $urandom_range(0, 4) == 0;
            PH_RFIN:   return $urandom_range(0, 14) != 0;
            default:   return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic logic [9:0] pick_ticks(input int hi);
        case ($urandom_range(0, 7))
            0: return 10'd0;
            1: return 10'd1;
            default: return 10'($urandom_range(1, hi));
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
        return 8'($urandom);
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [7:0] d, input logic p,
                             input logic l, input bit known, input t_result typed);
        t_result r;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, l, p, d};
        do @(posedge i_clk); while (!s_axis_tready);
        r = bus_step(op, d, p, l);
        owed_results.push_back(known ? typed : r);
        n_items++;
        if (op != OP_TICK && r.status_code == ST_BUSY) n_rejects++;
        if (r.done_res) begin
            n_done++;
            if (cmd == OP_RESET) n_reset_end[r.status_code]++;
        end
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Starts a command and ticks it to completion, with stray commands mixed in.
    task automatic run_command(input logic [2:0] op, input logic [7:0] d, input logic p,
                               input bit tidy);
        logic [2:0] stray;
        send_item(op, d, p, 1'($urandom_range(0, 1)), 1'b0, R_IDLE);
        while (ph != PH_IDLE) begin
            if ($urandom_range(0, 29) == 0) begin
                stray = 3'($urandom_range(OP_RESET, OP_SPARE7));
                send_item(stray, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, R_IDLE);
            end else begin
                send_item(OP_TICK, 8'($urandom), 1'($urandom), device_line(tidy), 1'b0,
                          R_IDLE);
            end
        end
    endtask

    task automatic load_config();
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= cfg_next[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            cfg_r[i] = (CFG_IDX_W'(i) == CFG_SPU_EN) ? {9'b0, cfg_next[i][0]} : cfg_next[i];
        end
        cfg_valid <= 1'b0;
        n_loads++;
    endtask

    // Stops offering items and waits until the block has answered all of them.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic report(input string what, input t_result want, input t_result got);
        n_err++;
        if (n_err <= MAX_REPORTS)
            $display({"%s: exp dl=%b dh=%b busy=%b done=%b rd=%h st=%0d crc=%h",
                      " | got dl=%b dh=%b busy=%b done=%b rd=%h st=%0d crc=%h pad=%b"},
                     what, want.drive_low, want.drive_high, want.busy_res, want.done_res,
                     want.read_value, want.status_code, want.crc_value, got.drive_low,
                     got.drive_high, got.busy_res, got.done_res, got.read_value,
                     got.status_code, got.crc_value, m_axis_tdata[23:22]);
    endtask

    initial begin : result_check
        int      stall;
        t_result got;
        t_result want;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_tready) begin
                got = m_axis_tdata[21:0];
                if (owed_results.size() == 0) begin
                    report("unexpected result", R_IDLE, got);
                end else begin
                    want = owed_results.pop_front();
                    if (got.drive_low !== want.drive_low || got.drive_high !== want.drive_high ||
                        got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                        got.read_value !== want.read_value ||
                        got.status_code !== want.status_code ||
                        got.crc_value !== want.crc_value || m_axis_tdata[23:22] !== 2'b00)
                        report("result mismatch", want, got);
                end
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                stall = $urandom_range(0, 11);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // One long receiver stall early in the random traffic, so the input side backs up.
    initial begin : backpressure
        while (!rand_on || n_items - rand_base < 200 || !s_tvalid) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin : watchdog
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int         pick;
        logic [2:0] op;
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table with the shortest timing the registers allow, but the largest long low time.
        cfg_next[CFG_RESET_LOW] = 10'd1;
        cfg_next[CFG_PRES_SAMP] = 10'd1;
        cfg_next[CFG_RESET_FIN] = 10'd1;
        cfg_next[CFG_SHORT_LOW] = 10'd0;
        cfg_next[CFG_LONG_LOW]  = 10'd1023;
        cfg_next[CFG_READ_SAMP] = 10'd0;
        cfg_next[CFG_SLOT]      = 10'd0;
        cfg_next[CFG_SPU_EN]    = 10'd1;
        load_config();
        for (int i = 0; i < N_DIR; i++)
            for (int k = 0; k < DIR_ROWS[i].reps; k++)
                send_item(DIR_ROWS[i].op, DIR_ROWS[i].data, DIR_ROWS[i].pull,
                          DIR_ROWS[i].line, DIR_ROWS[i].known, DIR_ROWS[i].want);
        drain();

        // Largest bit low and read sample times against a short slot: a reset, a write and a read bit.
        cfg_next[CFG_RESET_LOW] = 10'd40;
        cfg_next[CFG_PRES_SAMP] = 10'd20;
        cfg_next[CFG_RESET_FIN] = 10'd30;
        cfg_next[CFG_SHORT_LOW] = 10'd1023;
        cfg_next[CFG_LONG_LOW]  = 10'd1023;
        cfg_next[CFG_READ_SAMP] = 10'd1023;
        cfg_next[CFG_SLOT]      = 10'd12;
        cfg_next[CFG_SPU_EN]    = 10'd1023;
        load_config();
        run_command(OP_RESET, 8'h00, 1'b0, 1'b1);
        run_command(OP_WRITE, 8'ha5, 1'b1, 1'b1);
        run_command(OP_RBIT, 8'h00, 1'b0, 1'b1);
        drain();

        rand_on = 1'b1;
        rand_base = n_items;
        while (n_items - rand_base < RAND_ITEMS) begin
            cfg_next[CFG_RESET_LOW] = pick_ticks(6);
            cfg_next[CFG_PRES_SAMP] = pick_ticks(6);
            cfg_next[CFG_RESET_FIN] = pick_ticks(6);
            cfg_next[CFG_SHORT_LOW] = pick_ticks(10);
            cfg_next[CFG_LONG_LOW]  = pick_ticks(14);
            cfg_next[CFG_READ_SAMP] = pick_ticks(12);
            cfg_next[CFG_SLOT]      = pick_ticks(12);
            cfg_next[CFG_SPU_EN]    = 10'($urandom);
            load_config();
            repeat ($urandom_range(3, 8)) begin
                if (n_items - rand_base >= RAND_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
                if ($urandom_range(0, 5) == 0) begin
                    op = $urandom_range(0, 1) ? OP_TICK
                                              : 3'($urandom_range(OP_SPARE5, OP_SPARE7));
                    send_item(op, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, R_IDLE);
                end
                pick = $urandom_range(0, 99);
                op = (pick < 25) ? OP_RESET : (pick < 55) ? OP_WRITE :
                     (pick < 80) ? OP_RBYTE : OP_RBIT;
                run_command(op, pick_byte(), 1'($urandom), $urandom_range(0, 9) != 0);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        n_err += owed_results.size();
        $display("Sent %0d items over %0d register loads: %0d commands completed, %0d %s",
                 n_items, n_loads, n_done, n_rejects, "rejected as busy.");
        $display("Resets ended ok %0d, without presence %0d, %s %0d times.",
                 n_reset_end[ST_OK], n_reset_end[ST_NO_PRES], "with the line stuck low",
                 n_reset_end[ST_STUCK]);
        if (n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d failures", n_err);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
